### rtl/bqdf_pkg.sv
// Shared types, constants and the sequencer microcode for the biquad filter.
package bqdf_pkg;

   // Fixed formats of the coefficient, delay, product and accumulator words.
   localparam int COEF_W    = 18;
   localparam int DELAY_W   = 32;
   localparam int PROD_W    = COEF_W + DELAY_W;
   localparam int ACC_W     = PROD_W + 4;
   localparam int W_SHIFT   = 16;
   localparam int ACC_FRAC  = 41;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 3;

   // Reset values of the coefficients (Q2.16).
   localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_ZERO = 18'sd0;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_index_type;

   // Coefficient set as held by the configuration registers.
   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   // Multiplier coefficient select.
   typedef enum logic [2:0] {
      CS_A1,
      CS_A2,
      CS_B0,
      CS_B1,
      CS_B2
   } coef_sel_type;

   // Multiplier delay-word select.
   typedef enum logic [1:0] {
      OS_W1,
      OS_W2,
      OS_W
   } opnd_sel_type;

   // Accumulator operations.
   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_X,
      ACC_SUB,
      ACC_ADD,
      ACC_LOAD_PROD
   } acc_op_type;

   // Conditional jumps: stay at the target while the condition holds.
   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_WAIT_IN,
      JMP_WAIT_OUT
   } jmp_type;

   // One microcode word.
   typedef struct packed {
      jmp_type               jmp;
      logic [STEP_W-1:0]     target;
      logic                  take_in;
      logic                  load_out;
      coef_sel_type          coef_sel;
      opnd_sel_type          opnd_sel;
      acc_op_type            acc_op;
      logic                  load_w;
   } ctrl_word_type;

   // Control group from the sequencer to the datapath.
   typedef struct packed {
      logic                  take_in;
      logic                  load_out;
      coef_sel_type          coef_sel;
      opnd_sel_type          opnd_sel;
      acc_op_type            acc_op;
      logic                  load_w;
   } dp_ctrl_type;

   // Microcode program. The multiplier result is registered, so each
   // accumulate step uses the product started in the previous step.
   function automatic ctrl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_word_type word;
      word = '{jmp: JMP_NONE, target: '0, take_in: 1'b0, load_out: 1'b0,
               coef_sel: CS_A1, opnd_sel: OS_W1, acc_op: ACC_HOLD, load_w: 1'b0};
      unique case (step)
         // Wait for a sample and latch it with its delay pair.
         3'd0: begin
            word.jmp     = JMP_WAIT_IN;
            word.target  = 3'd0;
            word.take_in = 1'b1;
         end
         // Load the scaled sample, start a1*w1.
         3'd1: begin
            word.coef_sel = CS_A1;
            word.opnd_sel = OS_W1;
            word.acc_op   = ACC_LOAD_X;
         end
         // Subtract a1*w1, start a2*w2.
         3'd2: begin
            word.coef_sel = CS_A2;
            word.opnd_sel = OS_W2;
            word.acc_op   = ACC_SUB;
         end
         // Subtract a2*w2, start b1*w1.
         3'd3: begin
            word.coef_sel = CS_B1;
            word.opnd_sel = OS_W1;
            word.acc_op   = ACC_SUB;
         end
         // Take w from the finished sum, restart the sum with b1*w1, start b2*w2.
         3'd4: begin
            word.coef_sel = CS_B2;
            word.opnd_sel = OS_W2;
            word.acc_op   = ACC_LOAD_PROD;
            word.load_w   = 1'b1;
         end
         // Add b2*w2, start b0*w.
         3'd5: begin
            word.coef_sel = CS_B0;
            word.opnd_sel = OS_W;
            word.acc_op   = ACC_ADD;
         end
         // Add b0*w.
         3'd6: begin
            word.acc_op = ACC_ADD;
         end
         // Hand y to the output register once it is free; the counter then
         // wraps to the first step.
         3'd7: begin
            word.jmp      = JMP_WAIT_OUT;
            word.target   = 3'd7;
            word.load_out = 1'b1;
         end
         default: begin
            word.jmp = JMP_NONE;
         end
      endcase
      return word;
   endfunction

endpackage

### rtl/bqdf_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module bqdf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  out_busy,
   output logic                  in_ready,
   output bqdf_pkg::dp_ctrl_type ctrl
);
   import bqdf_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ctrl_word_type     word;
   logic              hold;

   // Decode the current word and evaluate its jump condition.
   always_comb begin
      word = rom_word(step_ff);
      unique case (word.jmp)
         JMP_WAIT_IN:  hold = !in_valid;
         JMP_WAIT_OUT: hold = out_busy;
         default:      hold = 1'b0;
      endcase
      step_in = hold ? word.target : step_ff + 1'b1;
   end

   // Drive the datapath; the handshake steps only act when not held.
   always_comb begin
      in_ready       = (word.jmp == JMP_WAIT_IN);
      ctrl.take_in   = word.take_in && !hold;
      ctrl.load_out  = word.load_out && !hold;
      ctrl.coef_sel  = word.coef_sel;
      ctrl.opnd_sel  = word.opnd_sel;
      ctrl.acc_op    = word.acc_op;
      ctrl.load_w    = word.load_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/bqdf_datapath.sv
// Shared multiply-accumulate datapath with rounding and saturation.
module bqdf_datapath #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                    clock,
   input  bqdf_pkg::dp_ctrl_type                   ctrl,
   input  bqdf_pkg::coef_set_type                  coefs,
   input  logic signed [SAMPLE_BITS-1:0]           sample,
   input  logic signed [bqdf_pkg::DELAY_W-1:0]     rd_w1,
   input  logic signed [bqdf_pkg::DELAY_W-1:0]     rd_w2,
   output logic signed [bqdf_pkg::DELAY_W-1:0]     w_out,
   output logic signed [bqdf_pkg::DELAY_W-1:0]     w1_out,
   output logic signed [SAMPLE_BITS-1:0]           y_out
);
   import bqdf_pkg::*;

   localparam int OUT_SHIFT = ACC_FRAC - SAMPLE_BITS;
   localparam logic signed [ACC_W-1:0] W_HI = (ACC_W'(1) <<< (DELAY_W - 1)) - 1;
   localparam logic signed [ACC_W-1:0] W_LO = -W_HI - 1;
   localparam logic signed [ACC_W-1:0] Y_HI = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [ACC_W-1:0] Y_LO = -Y_HI - 1;
   localparam logic signed [ACC_W-1:0] W_HALF = ACC_W'(1) <<< (W_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (OUT_SHIFT - 1);

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [DELAY_W-1:0]     w1_ff, w1_in;
   logic signed [DELAY_W-1:0]     w2_ff, w2_in;
   logic signed [DELAY_W-1:0]     w_ff, w_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;

   logic signed [COEF_W-1:0]      coef_mux;
   logic signed [DELAY_W-1:0]     opnd_mux;
   logic signed [ACC_W-1:0]       w_shr;
   logic signed [ACC_W-1:0]       y_shr;
   logic signed [DELAY_W-1:0]     w_sat;

   // Operand registers take the sample and its delay pair on acceptance.
   always_comb begin
      x_in  = ctrl.take_in ? sample : x_ff;
      w1_in = ctrl.take_in ? rd_w1 : w1_ff;
      w2_in = ctrl.take_in ? rd_w2 : w2_ff;
   end

   // Multiplier operand selection and registered product.
   always_comb begin
      case (ctrl.coef_sel)
         CS_A1:   coef_mux = coefs.a1;
         CS_A2:   coef_mux = coefs.a2;
         CS_B0:   coef_mux = coefs.b0;
         CS_B1:   coef_mux = coefs.b1;
         CS_B2:   coef_mux = coefs.b2;
         default: coef_mux = coefs.b0;
      endcase
      case (ctrl.opnd_sel)
         OS_W1:   opnd_mux = w1_ff;
         OS_W2:   opnd_mux = w2_ff;
         OS_W:    opnd_mux = w_ff;
         default: opnd_mux = w1_ff;
      endcase
      prod_in = PROD_W'(coef_mux * opnd_mux);
   end

   // Accumulator.
   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD_X:    acc_in = ACC_W'(x_ff) <<< OUT_SHIFT;
         ACC_SUB:       acc_in = acc_ff - ACC_W'(prod_ff);
         ACC_ADD:       acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_LOAD_PROD: acc_in = ACC_W'(prod_ff);
         default:       acc_in = acc_ff;
      endcase
   end

   // Round half up, then saturate w to the delay word range.
   always_comb begin
      w_shr = (acc_ff + W_HALF) >>> W_SHIFT;
      if (w_shr > W_HI) begin
         w_sat = DELAY_W'(W_HI);
      end else if (w_shr < W_LO) begin
         w_sat = DELAY_W'(W_LO);
      end else begin
         w_sat = DELAY_W'(w_shr);
      end
      w_in = ctrl.load_w ? w_sat : w_ff;
   end

   // Round half up, then saturate y to the sample range.
   always_comb begin
      y_shr = (acc_ff + Y_HALF) >>> OUT_SHIFT;
      if (y_shr > Y_HI) begin
         y_out = SAMPLE_BITS'(Y_HI);
      end else if (y_shr < Y_LO) begin
         y_out = SAMPLE_BITS'(Y_LO);
      end else begin
         y_out = SAMPLE_BITS'(y_shr);
      end
   end

   assign w_out  = w_ff;
   assign w1_out = w1_ff;

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      w1_ff   <= w1_in;
      w2_ff   <= w2_in;
      w_ff    <= w_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

### rtl/biquad_df2_allpass_filter.sv
// Top level of the multichannel Direct Form II biquad filter.
//
// Each accepted word carries one signed sample and its channel number; the
// block returns one filtered, saturated sample with the same channel number.
// From acceptance to the output register a sample takes one step to take
// the word, six steps through the single shared 18x32 multiplier and
// accumulator, and one step to load the output. The input is taken again
// once the result sits in the output register, so no new sample is accepted
// before the one in flight is through; a stalled output holds the sequencer
// in its last step. Coefficients are signed Q2.16 and should be written only
// while no sample is in flight. Delay words are cleared by reset.
module biquad_df2_allpass_filter #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample_in [SAMPLE_BITS-1:0], zero padded to whole bytes.
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   // req_tuser: chan_in [0].
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: sample_out [SAMPLE_BITS-1:0], zero padded to whole bytes.
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,
   // rsp_tuser: chan_out [0].
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bqdf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bqdf_pkg::COEF_W-1:0]         csr_data
);
   import bqdf_pkg::*;

   localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CHIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   dp_ctrl_type                   ctrl;
   coef_set_type                  coef_ff, coef_in;
   logic signed [DELAY_W-1:0]     delay_one_ff [CHANNELS];
   logic signed [DELAY_W-1:0]     delay_two_ff [CHANNELS];
   logic [CHIDX_W-1:0]            idx_in;
   logic [CHIDX_W-1:0]            idx_ff, idx_in_next;
   logic                          chan_ff, chan_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_chan_ff, rsp_chan_in;
   logic                          out_busy;
   logic signed [DELAY_W-1:0]     w_cur;
   logic signed [DELAY_W-1:0]     w1_cur;
   logic signed [SAMPLE_BITS-1:0] y_cur;

   // Delay pair used is the channel number modulo the channel count.
   assign idx_in = (CHANNELS > 1) ? CHIDX_W'(req_tuser) : '0;

   assign out_busy  = rsp_valid_ff && !rsp_tready;
   assign csr_ready = 1'b1;

   bqdf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_busy (out_busy),
      .in_ready (req_tready),
      .ctrl     (ctrl)
   );

   bqdf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock  (clock),
      .ctrl   (ctrl),
      .coefs  (coef_ff),
      .sample (req_tdata[SAMPLE_BITS-1:0]),
      .rd_w1  (delay_one_ff[idx_in]),
      .rd_w2  (delay_two_ff[idx_in]),
      .w_out  (w_cur),
      .w1_out (w1_cur),
      .y_out  (y_cur)
   );

   // Coefficient writes; unknown indexes are ignored.
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_B0:  coef_in.b0 = csr_data;
            REG_B1:  coef_in.b1 = csr_data;
            REG_B2:  coef_in.b2 = csr_data;
            REG_A1:  coef_in.a1 = csr_data;
            REG_A2:  coef_in.a2 = csr_data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   // Channel of the sample in flight.
   always_comb begin
      idx_in_next = ctrl.take_in ? idx_in : idx_ff;
      chan_in     = ctrl.take_in ? req_tuser : chan_ff;
   end

   // Output register.
   always_comb begin
      rsp_sample_in = ctrl.load_out ? y_cur : rsp_sample_ff;
      rsp_chan_in   = ctrl.load_out ? chan_ff : rsp_chan_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'($unsigned(rsp_sample_ff));
   assign rsp_tuser  = rsp_chan_ff;

   // Control state, coefficients and delay words.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         coef_ff      <= '{b0: COEF_ONE, b1: COEF_ZERO, b2: COEF_ZERO,
                           a1: COEF_ZERO, a2: COEF_ZERO};
         for (int i = 0; i < CHANNELS; i++) begin
            delay_one_ff[i] <= '0;
            delay_two_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         // The delay pair shifts when the result is handed over.
         if (ctrl.load_out) begin
            delay_two_ff[idx_ff] <= w1_cur;
            delay_one_ff[idx_ff] <= w_cur;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in_next;
      chan_ff       <= chan_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
   end

   // One sample is in flight at a time: acceptance closes the input.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input stayed open after a sample was accepted");

   // A result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> !out_busy)
      else $error("result loaded while output register was stalled");

   // A taken result without a new one empties the output register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !ctrl.load_out |=> !rsp_tvalid)
      else $error("output word repeated after it was taken");

   // The output is loaded only while the input is closed.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> !req_tready)
      else $error("result loaded while waiting for a new sample");

endmodule
